// ===== rtl/gha_pkg.sv =====
// Shared types and constants of the generational handle allocator.
package gha_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    localparam int HIDX_W = 10;
    localparam int GEN_W  = 8;
    localparam int LIVE_W = 11;

    // common width for index and count compares and conversions
    localparam int EXT_W = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;

    typedef enum logic [1:0] {
        REQ_CREATE  = 2'd0,
        REQ_DESTROY = 2'd1,
        REQ_CHECK   = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req_type;

    typedef struct packed {
        logic             alive;
        logic [GEN_W-1:0] gen;
    } t_slot_entry;

    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic [IDX_W-1:0] idx;
    } t_stack_entry;

    typedef struct packed {
        logic [HIDX_W-1:0] index;
        logic [GEN_W-1:0]  gen;
        logic              success;
        logic              pool_full;
        logic [LIVE_W-1:0] live;
    } t_result;

endpackage

// ===== rtl/generational_handle_allocator_top.sv =====
// Top level of the generational handle allocator with stream ports.
//
// Takes one request word per clock while the output is not stalled and returns one
// result word per request, in order, through the engine stage register and the
// result register. Requests are create, destroy, check and clear; a handle is a
// slot index plus an 8-bit generation. Throughput is one word per cycle when the
// output is not stalled, set by the single write port and registered read of the
// slot table and free stack memories, with read-during-write forwarding covering
// back-to-back requests on the same slot. No clearing pass runs after reset: the
// fresh-slot counter fences off table entries never written, so words are accepted
// from the first cycle. A clear request empties the pool by zeroing all counters.
module generational_handle_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [9:0] handle_index, [17:10] handle_generation
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [9:0] out_index, [17:10] out_generation,
                                          // [28:18] live_count
    output logic [1:0]  o_m_axis_tuser    // [0] success, [1] pool_full
);

    gha_pkg::t_result eng_res, out_res;
    logic             eng_valid, res_ready;

    gha_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_req       (gha_pkg::t_req_type'(i_s_axis_tuser)),
        .i_hidx      (i_s_axis_tdata[9:0]),
        .i_hgen      (i_s_axis_tdata[17:10]),
        .o_res_valid (eng_valid),
        .i_res_ready (res_ready),
        .o_res       (eng_res)
    );

    gha_result_reg u_result_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (eng_valid),
        .o_ready (res_ready),
        .i_res   (eng_res),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (out_res)
    );

    assign o_m_axis_tdata = {3'b000, out_res.live, out_res.gen, out_res.index};
    assign o_m_axis_tuser = {out_res.pool_full, out_res.success};

endmodule

// ===== rtl/gha_engine.sv =====
// Request stage: slot table, free stack, counters; one request/cycle unless stalled.
module gha_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  gha_pkg::t_req_type        i_req,
    input  logic [gha_pkg::HIDX_W-1:0] i_hidx,
    input  logic [gha_pkg::GEN_W-1:0]  i_hgen,
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output gha_pkg::t_result          o_res
);

    localparam int IDX_W = gha_pkg::IDX_W;
    localparam int CNT_W = gha_pkg::CNT_W;
    localparam int EXT_W = gha_pkg::EXT_W;
    localparam int GEN_W = gha_pkg::GEN_W;

    // stage register
    logic                       r_s1_valid;
    gha_pkg::t_req_type         r_req;
    logic [gha_pkg::HIDX_W-1:0] r_hidx;
    logic [GEN_W-1:0]           r_hgen;

    // bookkeeping
    logic [CNT_W-1:0] r_depth, n_depth;
    logic [CNT_W-1:0] r_fresh, n_fresh;
    logic [CNT_W-1:0] r_live,  n_live;

    // memories and their registered read words
    gha_pkg::t_slot_entry  r_tab_mem [0:gha_pkg::SLOT_COUNT-1];
    gha_pkg::t_stack_entry r_stk_mem [0:gha_pkg::SLOT_COUNT-1];
    gha_pkg::t_slot_entry  r_tab_q;
    gha_pkg::t_stack_entry r_stk_q;

    logic                  accept, advance;
    logic [EXT_W-1:0]      in_hidx_ext, hidx_ext, res_idx_ext, live_ext;
    logic [IDX_W-1:0]      tab_raddr, tab_waddr, stk_raddr, stk_waddr;
    logic [CNT_W-1:0]      depth_ahead, stk_rd_full;
    logic                  in_range, live_hit;
    logic                  tab_we_c, stk_we_c, tab_we, stk_we;
    gha_pkg::t_slot_entry  tab_wdata;
    gha_pkg::t_stack_entry stk_wdata;
    logic [GEN_W-1:0]      res_gen;
    logic                  ok, full;

    assign advance    = r_s1_valid && i_res_ready;
    assign o_in_ready = !r_s1_valid || i_res_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign in_hidx_ext = EXT_W'(i_hidx);
    assign hidx_ext    = EXT_W'(r_hidx);
    assign tab_raddr   = in_hidx_ext[IDX_W-1:0];

    // the next request pops from the depth this one leaves behind
    assign depth_ahead = advance ? n_depth : r_depth;
    assign stk_rd_full = depth_ahead - CNT_W'(1);
    assign stk_raddr   = stk_rd_full[IDX_W-1:0];

    assign in_range = hidx_ext < EXT_W'(r_fresh);
    assign live_hit = in_range && r_tab_q.alive && (r_tab_q.gen == r_hgen);

    always_comb begin
        n_depth     = r_depth;
        n_fresh     = r_fresh;
        n_live      = r_live;
        tab_we_c    = 1'b0;
        tab_waddr   = hidx_ext[IDX_W-1:0];
        tab_wdata   = '0;
        stk_we_c    = 1'b0;
        stk_waddr   = r_depth[IDX_W-1:0];
        stk_wdata   = '0;
        res_idx_ext = hidx_ext;
        res_gen     = r_hgen;
        ok          = 1'b0;
        full        = 1'b0;
        unique case (r_req)
            gha_pkg::REQ_CREATE: begin
                if (r_depth != '0) begin
                    n_depth         = r_depth - CNT_W'(1);
                    tab_we_c        = 1'b1;
                    tab_waddr       = r_stk_q.idx;
                    tab_wdata.alive = 1'b1;
                    tab_wdata.gen   = r_stk_q.gen;
                    res_idx_ext     = EXT_W'(r_stk_q.idx);
                    res_gen         = r_stk_q.gen;
                    n_live          = r_live + CNT_W'(1);
                    ok              = 1'b1;
                end else if (r_fresh < CNT_W'(gha_pkg::SLOT_COUNT)) begin
                    tab_we_c        = 1'b1;
                    tab_waddr       = r_fresh[IDX_W-1:0];
                    tab_wdata.alive = 1'b1;
                    tab_wdata.gen   = GEN_W'(1);
                    n_fresh         = r_fresh + CNT_W'(1);
                    res_idx_ext     = EXT_W'(r_fresh);
                    res_gen         = GEN_W'(1);
                    n_live          = r_live + CNT_W'(1);
                    ok              = 1'b1;
                end else begin
                    full = 1'b1;
                end
            end
            gha_pkg::REQ_DESTROY: begin
                if (live_hit && (r_depth < CNT_W'(gha_pkg::SLOT_COUNT))) begin
                    tab_we_c        = 1'b1;
                    tab_wdata.alive = 1'b0;
                    tab_wdata.gen   = r_tab_q.gen + GEN_W'(1);
                    // the stack entry carries the bumped generation for the next pop
                    stk_we_c        = 1'b1;
                    stk_wdata.gen   = r_tab_q.gen + GEN_W'(1);
                    stk_wdata.idx   = hidx_ext[IDX_W-1:0];
                    n_depth         = r_depth + CNT_W'(1);
                    if (r_live != '0) begin
                        n_live = r_live - CNT_W'(1);
                    end
                    ok = 1'b1;
                end
            end
            gha_pkg::REQ_CHECK: begin
                ok = live_hit;
            end
            gha_pkg::REQ_CLEAR: begin
                n_depth = '0;
                n_fresh = '0;
                n_live  = '0;
                ok      = 1'b1;
            end
        endcase
    end

    assign tab_we   = advance && tab_we_c;
    assign stk_we   = advance && stk_we_c;
    assign live_ext = EXT_W'(n_live);

    assign o_res_valid     = r_s1_valid;
    assign o_res.index     = res_idx_ext[gha_pkg::HIDX_W-1:0];
    assign o_res.gen       = res_gen;
    assign o_res.success   = ok;
    assign o_res.pool_full = full;
    assign o_res.live      = live_ext[gha_pkg::LIVE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_depth    <= '0;
            r_fresh    <= '0;
            r_live     <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_depth <= n_depth;
                r_fresh <= n_fresh;
                r_live  <= n_live;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req;
            r_hidx <= i_hidx;
            r_hgen <= i_hgen;
        end
    end

    // read-during-write passes the new word through
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab_mem[tab_waddr] <= tab_wdata;
        end
        if (accept) begin
            r_tab_q <= (tab_we && (tab_waddr == tab_raddr)) ? tab_wdata
                                                            : r_tab_mem[tab_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_waddr] <= stk_wdata;
        end
        if (accept) begin
            r_stk_q <= (stk_we && (stk_waddr == stk_raddr)) ? stk_wdata
                                                            : r_stk_mem[stk_raddr];
        end
    end

`ifndef NO_ASSERTIONS
    // every slot handed out is either live or waiting on the free stack
    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((CNT_W+1)'(r_depth) + (CNT_W+1)'(r_live)) == (CNT_W+1)'(r_fresh))
        else $error("free depth plus live count differs from slots handed out");

    a_full_only_create: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && o_res.pool_full) |->
            (r_req == gha_pkg::REQ_CREATE) && (r_depth == '0) && !o_res.success)
        else $error("pool full flagged outside an exhausted create");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_req == gha_pkg::REQ_CLEAR)) |=>
            (r_live == '0) && (r_depth == '0) && (r_fresh == '0))
        else $error("clear left state behind");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !i_res_ready) |=>
            r_s1_valid && $stable(r_req) && $stable(r_hidx) && $stable(r_live))
        else $error("stage changed while stalled");
`endif

endmodule

// ===== rtl/gha_result_reg.sv =====
// Result register between the request stage and the output stream.
module gha_result_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  gha_pkg::t_result i_res,
    output logic             o_valid,
    input  logic             i_ready,
    output gha_pkg::t_result o_res
);

    logic             r_valid;
    gha_pkg::t_result r_res;
    logic             load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_res;
        end
    end

endmodule
